>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the exposure sequencer.
// Each macro expands to one labeled concurrent assertion on clock/reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/des_pkg.sv
// Package for the detector exposure sequencer: command, state and error codes,
// register indexes and the readout time table. No dependencies.
`default_nettype none

package des_pkg;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_EXPOSING = 3'd1,
      ST_READING  = 3'd2,
      ST_RETRY    = 3'd3,
      ST_ERROR    = 3'd4
   } state_type;

   typedef enum logic [2:0] {
      ER_NONE     = 3'd0,
      ER_NOT_INIT = 3'd1,
      ER_START    = 3'd2,
      ER_STOP     = 3'd3,
      ER_ABORT    = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      FN_TICK   = 4'd0,
      FN_INIT   = 4'd1,
      FN_START  = 4'd2,
      FN_STOP   = 4'd3,
      FN_QUERY  = 4'd4,
      FN_ABORT  = 4'd5,
      FN_RESET  = 4'd6,
      FN_RETRY  = 4'd7,
      FN_IMAGE  = 4'd8
   } func_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DETECTOR_MODEL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_TWO_BY_TWO   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADC_HARDWARE_BIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_TIME_MS     = 3'd3;

   localparam logic [2:0]  MODEL_RESET     = 3'd3;
   localparam logic [15:0] INIT_TIME_RESET = 16'd2000;
   localparam logic [2:0]  MODEL_LAST_ROW  = 3'd6;

   localparam logic [1:0] COL_1X1    = 2'd0;
   localparam logic [1:0] COL_2X2_HW = 2'd1;
   localparam logic [1:0] COL_2X2_SW = 2'd2;

   // Readout time in ms per detector model; columns 1x1, 2x2 hardware, 2x2 software
   localparam logic [15:0] READOUT_MS_TABLE [0:6][0:2] = '{
      '{16'd6000, 16'd2000, 16'd6000},
      '{16'd3000, 16'd1000, 16'd3000},
      '{16'd1100, 16'd420,  16'd1100},
      '{16'd900,  16'd250,  16'd900},
      '{16'd1100, 16'd370,  16'd1100},
      '{16'd1100, 16'd420,  16'd1100},
      '{16'd900,  16'd250,  16'd900}
   };

   function automatic logic [15:0] readout_ms(input logic [2:0] model,
                                              input logic bin2,
                                              input logic hw_bin);
      logic [2:0] row;
      logic [1:0] col;
      row = (model > MODEL_LAST_ROW) ? MODEL_LAST_ROW : model;
      if (!bin2) begin
         col = COL_1X1;
      end else if (hw_bin) begin
         col = COL_2X2_HW;
      end else begin
         col = COL_2X2_SW;
      end
      return READOUT_MS_TABLE[row][col];
   endfunction

endpackage

`default_nettype wire

>>> design/detector_exposure_sequencer_top.sv
// Detector exposure sequencer: command-driven state machine with elapsed-time
// counters and a registered result stage. Depends on des_pkg and assert_macros.svh.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | func, retry_value
//   rsp     | out | rsp_valid/rsp_ready  | status_code, machine_state_out,
//           |     |                      | error_reason, initialized_out
//   csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One command per cycle; result appears in the cycle after the transfer.
// The result register is the only buffer: a new command is taken whenever it
// is empty or being drained in the same cycle, so a stalled rsp stalls req.
// Synchronous reset puts the machine in the error state, not initialized.
// csr writes are always taken: csr_ready is tied high.
`default_nettype none

`include "assert_macros.svh"

module detector_exposure_sequencer_top
   import des_pkg::*;
#(
   parameter int TIMER_BITS = 16,
   parameter int RETRY_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [3:0]             req_func,
   input  wire logic [7:0]             req_retry_value,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_status_code,
   output logic [2:0]                  rsp_machine_state_out,
   output logic [2:0]                  rsp_error_reason,
   output logic                        rsp_initialized_out,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CMP_W   = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam int RCMP_W  = (RETRY_BITS > 8) ? RETRY_BITS : 8;

   // configuration
   logic [2:0]  model_ff;
   logic        bin2_ff;
   logic        hw_bin_ff;
   logic [15:0] init_time_ff;

   // machine state
   state_type             state_ff, state_in;
   logic                  initialized_ff, initialized_in;
   logic                  initializing_ff, initializing_in;
   logic [RETRY_BITS-1:0] retries_ff, retries_in;
   logic [TIMER_BITS-1:0] init_elapsed_ff, init_elapsed_in;
   logic [TIMER_BITS-1:0] readout_elapsed_ff, readout_elapsed_in;
   err_type               last_error_ff, last_error_in;
   logic                  status_in;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff;
   logic [2:0] rsp_state_ff;
   logic [2:0] rsp_error_ff;
   logic       rsp_init_ff;

   logic req_xfer;
   logic rsp_tracks_state;
   logic [CMP_W-1:0]  readout_limit, init_limit, readout_cnt, init_cnt;
   logic [RCMP_W-1:0] retry_ext, retry_max;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign readout_limit = CMP_W'(readout_ms(model_ff, bin2_ff, hw_bin_ff));
   assign init_limit    = CMP_W'(init_time_ff);
   assign readout_cnt   = CMP_W'(readout_elapsed_ff);
   assign init_cnt      = CMP_W'(init_elapsed_ff);
   assign retry_ext     = RCMP_W'(req_retry_value);
   assign retry_max     = RCMP_W'({RETRY_BITS{1'b1}});

   always_comb begin
      state_in           = state_ff;
      initialized_in     = initialized_ff;
      initializing_in    = initializing_ff;
      retries_in         = retries_ff;
      init_elapsed_in    = init_elapsed_ff;
      readout_elapsed_in = readout_elapsed_ff;
      last_error_in      = last_error_ff;
      status_in          = 1'b0;
      case (req_func)
         FN_TICK: begin
            if (init_elapsed_ff != {TIMER_BITS{1'b1}}) begin
               init_elapsed_in = init_elapsed_ff + TIMER_BITS'(1);
            end
            if (readout_elapsed_ff != {TIMER_BITS{1'b1}}) begin
               readout_elapsed_in = readout_elapsed_ff + TIMER_BITS'(1);
            end
         end
         FN_INIT: begin
            initialized_in     = 1'b0;
            initializing_in    = 1'b1;
            state_in           = ST_ERROR;
            retries_in         = '0;
            last_error_in      = ER_NONE;
            init_elapsed_in    = '0;
            readout_elapsed_in = '0;
         end
         FN_START: begin
            if (!initialized_ff) begin
               status_in = 1'b1; state_in = ST_ERROR; last_error_in = ER_NOT_INIT;
            end else if (state_ff != ST_IDLE) begin
               status_in = 1'b1; state_in = ST_ERROR; last_error_in = ER_START;
            end else begin
               state_in = ST_EXPOSING;
            end
         end
         FN_STOP: begin
            if (!initialized_ff) begin
               status_in = 1'b1; state_in = ST_ERROR; last_error_in = ER_NOT_INIT;
            end else if (state_ff != ST_EXPOSING) begin
               status_in = 1'b1; state_in = ST_ERROR; last_error_in = ER_STOP;
            end else if (retries_ff != '0) begin
               state_in   = ST_RETRY;
               retries_in = retries_ff - RETRY_BITS'(1);
            end else begin
               state_in           = ST_READING;
               readout_elapsed_in = '0;
            end
         end
         FN_QUERY: begin
            if (state_ff == ST_READING && readout_cnt > readout_limit) begin
               state_in = ST_IDLE;
            end else if (initializing_ff && init_cnt > init_limit) begin
               state_in        = ST_IDLE;
               initializing_in = 1'b0;
               initialized_in  = 1'b1;
            end
         end
         FN_ABORT: begin
            if (initializing_ff) begin
               status_in     = 1'b1;
               last_error_in = ER_ABORT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         FN_RESET: begin
            state_in      = ST_IDLE;
            last_error_in = ER_NONE;
         end
         FN_RETRY: begin
            retries_in = RETRY_BITS'((retry_ext > retry_max) ? retry_max : retry_ext);
         end
         FN_IMAGE: begin
            if (!initialized_ff) begin
               status_in = 1'b1; state_in = ST_ERROR; last_error_in = ER_NOT_INIT;
            end
         end
         default: begin
            status_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff           <= MODEL_RESET;
         bin2_ff            <= 1'b0;
         hw_bin_ff          <= 1'b0;
         init_time_ff       <= INIT_TIME_RESET;
         state_ff           <= ST_ERROR;
         initialized_ff     <= 1'b0;
         initializing_ff    <= 1'b0;
         retries_ff         <= '0;
         init_elapsed_ff    <= '0;
         readout_elapsed_ff <= '0;
         last_error_ff      <= ER_NONE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DETECTOR_MODEL:   model_ff     <= csr_data[2:0];
               CSR_BIN_TWO_BY_TWO:   bin2_ff      <= csr_data[0];
               CSR_ADC_HARDWARE_BIN: hw_bin_ff    <= csr_data[0];
               CSR_INIT_TIME_MS:     init_time_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_xfer) begin
            state_ff           <= state_in;
            initialized_ff     <= initialized_in;
            initializing_ff    <= initializing_in;
            retries_ff         <= retries_in;
            init_elapsed_ff    <= init_elapsed_in;
            readout_elapsed_ff <= readout_elapsed_in;
            last_error_ff      <= last_error_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on each req transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_status_ff <= status_in;
         rsp_state_ff  <= state_in;
         rsp_error_ff  <= last_error_in;
         rsp_init_ff   <= initialized_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status_code       = rsp_status_ff;
   assign rsp_machine_state_out = rsp_state_ff;
   assign rsp_error_reason      = rsp_error_ff;
   assign rsp_initialized_out   = rsp_init_ff;

   assign rsp_tracks_state = (rsp_state_ff == state_ff) && (rsp_init_ff == initialized_ff);

   `ASSERT_NEXT(a_xfer_gives_rsp, req_xfer, rsp_valid, "req transfer without result")
   `ASSERT_ALWAYS(a_init_flags_excl, !(initialized_ff && initializing_ff), "init flags both set")
   `ASSERT_NEXT(a_rsp_matches_state, req_xfer, rsp_tracks_state, "result differs from state")

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for detector_exposure_sequencer_top: a directed command table, random command
// sessions over several register settings, and a late init-time check at counter max.
// Results are checked against a local predictor. Depends on des_pkg and the sequencer RTL.

module tb;
   import des_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1350;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned LATE_TICKS   = 40;
   localparam logic [3:0]  FN_UNUSED_LO = 4'd9;
   localparam logic [3:0]  FN_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic      status;
      state_type machine;
      err_type   reason;
      logic      inited;
   } result_type;

   typedef struct packed {
      logic [3:0] fn;
      logic [7:0] rv;
      logic       typed;
      result_type want;
   } script_row_type;

   localparam result_type PREDICTED = '0;

   // Typed rows hold values that follow directly from the command; the rest use the predictor.
   localparam script_row_type SCRIPT [26] = '{
      '{FN_QUERY,     8'h00, 1'b1, '{1'b0, ST_ERROR, ER_NONE,     1'b0}},
      '{FN_START,     8'hFF, 1'b1, '{1'b1, ST_ERROR, ER_NOT_INIT, 1'b0}},
      '{FN_STOP,      8'h00, 1'b1, '{1'b1, ST_ERROR, ER_NOT_INIT, 1'b0}},
      '{FN_IMAGE,     8'h00, 1'b1, '{1'b1, ST_ERROR, ER_NOT_INIT, 1'b0}},
      '{FN_ABORT,     8'h00, 1'b1, '{1'b0, ST_IDLE,  ER_NOT_INIT, 1'b0}},
      '{FN_RESET,     8'h00, 1'b1, '{1'b0, ST_IDLE,  ER_NONE,     1'b0}},
      '{FN_UNUSED_HI, 8'hAA, 1'b1, '{1'b1, ST_IDLE,  ER_NONE,     1'b0}},
      '{FN_UNUSED_LO, 8'h55, 1'b1, '{1'b1, ST_IDLE,  ER_NONE,     1'b0}},
      '{FN_RETRY,     8'hFF, 1'b1, '{1'b0, ST_IDLE,  ER_NONE,     1'b0}},
      '{FN_INIT,      8'h00, 1'b1, '{1'b0, ST_ERROR, ER_NONE,     1'b0}},
      '{FN_ABORT,     8'h00, 1'b1, '{1'b1, ST_ERROR, ER_ABORT,    1'b0}},
      '{FN_QUERY,     8'h00, 1'b0, PREDICTED},
      '{FN_TICK,      8'h00, 1'b0, PREDICTED},
      '{FN_QUERY,     8'h00, 1'b0, PREDICTED},
      '{FN_RETRY,     8'h01, 1'b0, PREDICTED},
      '{FN_START,     8'h00, 1'b0, PREDICTED},
      '{FN_START,     8'h00, 1'b1, '{1'b1, ST_ERROR, ER_START,    1'b1}},
      '{FN_RESET,     8'h00, 1'b0, PREDICTED},
      '{FN_START,     8'h00, 1'b0, PREDICTED},
      '{FN_STOP,      8'h00, 1'b0, PREDICTED},
      '{FN_STOP,      8'h00, 1'b1, '{1'b1, ST_ERROR, ER_STOP,     1'b1}},
      '{FN_RESET,     8'h00, 1'b0, PREDICTED},
      '{FN_START,     8'h00, 1'b0, PREDICTED},
      '{FN_STOP,      8'h00, 1'b0, PREDICTED},
      '{FN_QUERY,     8'h00, 1'b0, PREDICTED},
      '{FN_IMAGE,     8'h00, 1'b0, PREDICTED}
   };

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [3:0]             req_func        = FN_TICK;
   logic [7:0]             req_retry_value = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic                   rsp_status_code;
   logic [2:0]             rsp_machine_state_out;
   logic [2:0]             rsp_error_reason;
   logic                   rsp_initialized_out;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_DETECTOR_MODEL;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;

   detector_exposure_sequencer_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_retry_value       (req_retry_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status_code       (rsp_status_code),
      .rsp_machine_state_out (rsp_machine_state_out),
      .rsp_error_reason      (rsp_error_reason),
      .rsp_initialized_out   (rsp_initialized_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   // predictor copy of registers and machine state
   logic [2:0]  cfg_model         = MODEL_RESET;
   logic        cfg_bin2          = 1'b0;
   logic        cfg_hw_bin        = 1'b0;
   logic [15:0] cfg_init_ms       = INIT_TIME_RESET;
   state_type   seq_state         = ST_ERROR;
   logic        seq_inited        = 1'b0;
   logic        seq_initing       = 1'b0;
   logic [7:0]  seq_retries       = 8'd0;
   logic [15:0] init_ms_count     = 16'd0;
   logic [15:0] readout_ms_count  = 16'd0;
   err_type     seq_err           = ER_NONE;

   result_type  pending_results [$];
   int unsigned commands_sent     = 0;
   int unsigned results_checked   = 0;
   int unsigned reg_writes        = 0;
   int unsigned mismatches        = 0;
   int unsigned readouts_done     = 0;
   int unsigned inits_done        = 0;
   int unsigned sessions          = 0;

   bit          idle_on           = 1'b1;
   bit          hold_req          = 1'b0;
   bit          rsp_taken         = 1'b0;
   int unsigned stall_left        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] readout_time_ms();
      logic [15:0] full_ms;
      logic [15:0] binned_ms;
      case ((cfg_model > MODEL_LAST_ROW) ? MODEL_LAST_ROW : cfg_model)
         3'd0: begin full_ms = 16'd6000; binned_ms = 16'd2000; end
         3'd1: begin full_ms = 16'd3000; binned_ms = 16'd1000; end
         3'd2: begin full_ms = 16'd1100; binned_ms = 16'd420;  end
         3'd3: begin full_ms = 16'd900;  binned_ms = 16'd250;  end
         3'd4: begin full_ms = 16'd1100; binned_ms = 16'd370;  end
         3'd5: begin full_ms = 16'd1100; binned_ms = 16'd420;  end
         default: begin full_ms = 16'd900; binned_ms = 16'd250; end
      endcase
      // software 2x2 binning reads out as slowly as 1x1
      return (cfg_bin2 && cfg_hw_bin) ? binned_ms : full_ms;
   endfunction

   function automatic void refuse(input err_type why);
      seq_state = ST_ERROR;
      seq_err   = why;
   endfunction

   function automatic result_type apply_command(input logic [3:0] fn, input logic [7:0] rv);
      result_type r;
      r.status = 1'b0;
      case (fn)
         FN_TICK: begin
            if (init_ms_count != 16'hFFFF) init_ms_count++;
            if (readout_ms_count != 16'hFFFF) readout_ms_count++;
         end
         FN_INIT: begin
            seq_inited       = 1'b0;
            seq_initing      = 1'b1;
            seq_state        = ST_ERROR;
            seq_retries      = 8'd0;
            seq_err          = ER_NONE;
            init_ms_count    = 16'd0;
            readout_ms_count = 16'd0;
         end
         FN_START: begin
            if (!seq_inited) begin
               refuse(ER_NOT_INIT);
               r.status = 1'b1;
            end else if (seq_state != ST_IDLE) begin
               refuse(ER_START);
               r.status = 1'b1;
            end else begin
               seq_state = ST_EXPOSING;
            end
         end
         FN_STOP: begin
            if (!seq_inited) begin
               refuse(ER_NOT_INIT);
               r.status = 1'b1;
            end else if (seq_state != ST_EXPOSING) begin
               refuse(ER_STOP);
               r.status = 1'b1;
            end else if (seq_retries != 8'd0) begin
               seq_state = ST_RETRY;
               seq_retries--;
            end else begin
               seq_state        = ST_READING;
               readout_ms_count = 16'd0;
            end
         end
         FN_QUERY: begin
            if (seq_state == ST_READING && readout_ms_count > readout_time_ms()) begin
               seq_state = ST_IDLE;
               readouts_done++;
            end else if (seq_initing && init_ms_count > cfg_init_ms) begin
               seq_state   = ST_IDLE;
               seq_initing = 1'b0;
               seq_inited  = 1'b1;
               inits_done++;
            end
         end
         FN_ABORT: begin
            if (seq_initing) begin
               r.status = 1'b1;
               seq_err  = ER_ABORT;
            end else begin
               seq_state = ST_IDLE;
            end
         end
         FN_RESET: begin
            seq_state = ST_IDLE;
            seq_err   = ER_NONE;
         end
         FN_RETRY: seq_retries = rv;
         FN_IMAGE: begin
            if (!seq_inited) begin
               refuse(ER_NOT_INIT);
               r.status = 1'b1;
            end
         end
         default: r.status = 1'b1;
      endcase
      r.machine = seq_state;
      r.reason  = seq_err;
      r.inited  = seq_inited;
      return r;
   endfunction

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      mismatches++;
      $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
               what, results_checked, got, want);
   endtask

   // one command transfer; the expectation is queued when the transfer happens
   task automatic issue(input logic [3:0] fn, input logic [7:0] rv, input logic typed,
                        input result_type want);
      int unsigned gap;
      result_type  predicted;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= fn;
      req_retry_value <= rv;
      do @(posedge clock); while (!req_ready);
      predicted = apply_command(fn, rv);
      commands_sent++;
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic send(input logic [3:0] fn, input logic [7:0] rv);
      issue(fn, rv, 1'b0, PREDICTED);
   endtask

   // occasionally slips a random command (any code) in front of the intended one
   task automatic noisy(input logic [3:0] fn, input logic [7:0] rv);
      if ($urandom_range(0, 19) == 0) begin
         send(4'($urandom_range(0, FN_UNUSED_HI)), any_byte());
      end
      send(fn, rv);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DETECTOR_MODEL:   cfg_model   = value[2:0];
         CSR_BIN_TWO_BY_TWO:   cfg_bin2    = value[0];
         CSR_ADC_HARDWARE_BIN: cfg_hw_bin  = value[0];
         CSR_INIT_TIME_MS:     cfg_init_ms = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // new settings, then init, exposures with retries, readouts, recovery paths
   task automatic run_session(input bit with_hold);
      logic [15:0] v;
      bit          fast_bin;
      int unsigned guard;
      int unsigned readout;
      wait_drain();
      idle_on  = ($urandom_range(0, 3) != 0);
      fast_bin = ($urandom_range(0, 1) == 1);
      v = 16'($urandom);
      write_reg(CSR_DETECTOR_MODEL, v);
      v = 16'($urandom);
      if (fast_bin) v[0] = 1'b1;
      write_reg(CSR_BIN_TWO_BY_TWO, v);
      v = 16'($urandom);
      if (fast_bin) v[0] = 1'b1;
      write_reg(CSR_ADC_HARDWARE_BIN, v);
      case ($urandom_range(0, 7))
         0: v = 16'd0;
         1: v = 16'd1;
         default: v = 16'($urandom_range(2, 30));
      endcase
      write_reg(CSR_INIT_TIME_MS, v);

      noisy(FN_INIT, any_byte());
      if (with_hold) hold_req = 1'b1;
      repeat (cfg_init_ms) send(FN_TICK, any_byte());
      // exactly at the init time the query must not finish yet
      noisy(FN_QUERY, any_byte());
      if (seq_initing) begin
         send(FN_TICK, any_byte());
         noisy(FN_QUERY, any_byte());
      end

      repeat ($urandom_range(2, 5)) begin
         if ($urandom_range(0, 2) == 0) begin
            noisy(FN_RETRY, ($urandom_range(0, 3) == 0) ? any_byte()
                                                        : 8'($urandom_range(0, 2)));
         end
         noisy(FN_START, any_byte());
         noisy(FN_STOP, any_byte());
         guard = 0;
         while (seq_state == ST_RETRY && guard < 4) begin
            noisy($urandom_range(0, 1) ? FN_RESET : FN_ABORT, any_byte());
            noisy(FN_START, any_byte());
            noisy(FN_STOP, any_byte());
            guard++;
         end
         if (seq_state == ST_READING) begin
            readout = readout_time_ms();
            // full readouts only while the item budget has room for them
            if (readout <= 420 && commands_sent + readout < ITEM_TARGET
                && $urandom_range(0, 1) == 0) begin
               repeat (readout) send(FN_TICK, any_byte());
               send(FN_QUERY, any_byte());
               send(FN_TICK, any_byte());
               send(FN_QUERY, any_byte());
            end else begin
               repeat ($urandom_range(0, 6)) send(FN_TICK, any_byte());
               noisy(FN_QUERY, any_byte());
               noisy($urandom_range(0, 1) ? FN_ABORT : FN_RESET, any_byte());
            end
         end else begin
            noisy(FN_RESET, any_byte());
         end
         if ($urandom_range(0, 3) == 0) noisy(FN_IMAGE, any_byte());
      end
   endtask

   // receiver: random stall after each transfer while idle_on is set, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req   = 1'b0;
         stall_left = HOLD_CYCLES;
      end else if (rsp_taken) begin
         rsp_taken  = 1'b0;
         stall_left = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         results_checked++;
         if (pending_results.size() == 0) begin
            report("result with no command pending", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status_code !== want.status)
               report("status_code", rsp_status_code, want.status);
            if (rsp_machine_state_out !== want.machine)
               report("machine_state_out", rsp_machine_state_out, want.machine);
            if (rsp_error_reason !== want.reason)
               report("error_reason", rsp_error_reason, want.reason);
            if (rsp_initialized_out !== want.inited)
               report("initialized_out", rsp_initialized_out, want.inited);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: no transfer for %0d cycles, %0d results pending",
               QUIET_LIMIT, pending_results.size());
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(CSR_INIT_TIME_MS, 16'd0);
      for (int i = 0; i < $size(SCRIPT); i++) begin
         issue(SCRIPT[i].fn, SCRIPT[i].rv, SCRIPT[i].typed, SCRIPT[i].want);
      end

      while (commands_sent < ITEM_TARGET) begin
         run_session(sessions % 5 == 0);
         sessions++;
      end

      // init time at counter max: a query cannot finish the initialization
      wait_drain();
      idle_on = 1'b0;
      write_reg(CSR_INIT_TIME_MS, 16'hFFFF);
      send(FN_INIT, any_byte());
      repeat (LATE_TICKS) send(FN_TICK, any_byte());
      send(FN_QUERY, any_byte());
      send(FN_ABORT, any_byte());

      wait_drain();
      $display("tb: %0d commands in %0d sessions, %0d results checked, %0d register writes",
               commands_sent, sessions, results_checked, reg_writes);
      $display("tb: %0d initializations and %0d readouts completed, %0d mismatches",
               inits_done, readouts_done, mismatches);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/des_pkg.sv
design/detector_exposure_sequencer_top.sv
dv/tb.sv
